/* rtl/core/mpqa_pkg.sv */
// Shared types for the min priority queue array: request and response
// payloads, status codes and the stored entry layout. No dependencies.
package mpqa_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] removed_value;
    logic signed [31:0] removed_priority;
    logic [7:0]         entry_count;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

endpackage

/* rtl/core/min_priority_queue_array.sv */
// Min priority queue kept as an unsorted array in one entry RAM, with a
// scan and shift sequencer. Depends on mpqa_pkg and mpqa_ram.
//
//   channel   signals                       payload
//   request   req_valid / req_ready / req   mpqa_pkg::req_t
//   response  rsp_valid / rsp_ready / rsp   mpqa_pkg::rsp_t
//
// Insert, overflow and underflow are answered directly from idle, with no scan.
// A remove scans every stored entry once through the RAM read port, then
// the shift moves each entry after the minimum down by one, one read and
// one write per cycle.
// Reset clears the count and the control state; RAM contents are left as is.
// A request is taken only in idle while the response register is free or
// being drained; a finished remove waits for the response register.
module min_priority_queue_array #(
  parameter int CAPACITY = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  mpqa_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output mpqa_pkg::rsp_t  rsp
);

  import mpqa_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t             state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      rd_idx;
  logic [CW-1:0]      pend_idx;
  logic               rd_pend;
  logic [AW-1:0]      best_idx;
  entry_t             best;

  logic               slot_free;
  logic               accept;
  logic               issue;
  logic               rsp_load;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  entry_t             mem_wdata;
  entry_t             mem_rdata;
  logic               take_new;
  logic [AW-1:0]      best_idx_next;
  entry_t             best_next;

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && slot_free;
  assign accept    = req_valid && req_ready;
  assign issue     = ((state == S_SCAN) || (state == S_SHIFT)) && (rd_idx < count);
  assign rsp_load  = (accept && ((req.mode == MODE_INSERT) || (count == '0))) ||
                     ((state == S_RESP) && slot_free);

  // RAM write: append on an insert that fits, move down during shift
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = '{value: req.item_value, prio: req.item_priority};
    if (state == S_SHIFT) begin
      mem_we    = rd_pend;
      mem_waddr = AW'(pend_idx - ONE);
      mem_wdata = mem_rdata;
    end else if (accept && req.mode == MODE_INSERT && count < CAP) begin
      mem_we = 1'b1;
    end
  end

  // running minimum; earliest entry wins on a tie
  always_comb begin
    take_new      = rd_pend && ((pend_idx == '0) || (mem_rdata.prio < best.prio));
    best_idx_next = take_new ? AW'(pend_idx) : best_idx;
    best_next     = take_new ? mem_rdata : best;
  end

  mpqa_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (issue),
    .raddr (rd_idx[AW-1:0]),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_idx    <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_pend   <= issue;
      pend_idx  <= rd_idx;
      rsp_valid <= rsp_load || (rsp_valid && !rsp_ready);
      if (issue) begin
        rd_idx <= rd_idx + ONE;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rsp.removed_value    <= '0;
            rsp.removed_priority <= '0;
            if (req.mode == MODE_INSERT) begin
              if (count < CAP) begin
                count           <= count + ONE;
                rsp.status      <= ST_OK;
                rsp.entry_count <= 8'(count + ONE);
              end else begin
                rsp.status      <= ST_OVERFLOW;
                rsp.entry_count <= 8'(count);
              end
            end else if (count == '0) begin
              rsp.status      <= ST_UNDERFLOW;
              rsp.entry_count <= 8'(count);
            end else begin
              rd_idx <= '0;
              state  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          best_idx <= best_idx_next;
          best     <= best_next;
          if (rd_pend && pend_idx == count - ONE) begin
            rd_idx <= CW'(best_idx_next) + ONE;
            state  <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (!issue && !rd_pend) begin
            count <= count - ONE;
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (slot_free) begin
            rsp.status           <= ST_OK;
            rsp.removed_value    <= best.value;
            rsp.removed_priority <= best.prio;
            rsp.entry_count      <= 8'(count);
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP)
    else $error("entry count above capacity");

  a_insert_rsp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req.mode == MODE_INSERT) |=> rsp_valid)
    else $error("insert without response");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |->
      (rsp.removed_value == '0 && rsp.removed_priority == '0))
    else $error("failed request carries removed data");

  a_seq_busy: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) || (state == S_SHIFT)) |-> (!req_ready && count != '0))
    else $error("request taken or empty queue during remove");

endmodule

/* rtl/core/mpqa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module mpqa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
